@@ hdl/lwpcw_pkg.sv @@
// ----------------------------------------------------------------------------
// lwpcw_pkg
// Shared types and constants of the lcd window pixel command writer.
// ----------------------------------------------------------------------------
package lwpcw_pkg;

	// request kinds on the input channel
	localparam logic [2:0] KIND_OPEN   = 3'd0;
	localparam logic [2:0] KIND_RGB888 = 3'd1;
	localparam logic [2:0] KIND_RGB565 = 3'd2;
	localparam logic [2:0] KIND_CLOSE  = 3'd3;
	localparam logic [2:0] KIND_CURSOR = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_ORIENTATION = 2'd0;
	localparam logic [1:0] CFG_WIDTH       = 2'd1;
	localparam logic [1:0] CFG_HEIGHT      = 2'd2;
	localparam logic [1:0] CFG_ENTRY_MODE  = 2'd3;

	// orientations
	localparam logic [1:0] ORIENT_PORTRAIT       = 2'd0;
	localparam logic [1:0] ORIENT_LANDSCAPE      = 2'd1;
	localparam logic [1:0] ORIENT_PORTRAIT_FLIP  = 2'd2;
	localparam logic [1:0] ORIENT_LANDSCAPE_FLIP = 2'd3;

	// panel register indexes
	localparam logic [15:0] CMD_ENTRY_MODE = 16'h0011;
	localparam logic [15:0] CMD_H_START    = 16'h0045;
	localparam logic [15:0] CMD_H_END      = 16'h0046;
	localparam logic [15:0] CMD_V_BOUNDS   = 16'h0044;
	localparam logic [15:0] CMD_CURSOR_X   = 16'h004e;
	localparam logic [15:0] CMD_CURSOR_Y   = 16'h004f;
	localparam logic [15:0] CMD_RAM_WRITE  = 16'h0022;

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// data words carried by one queued request
	localparam int NUM_DATA = 6;

	typedef enum logic [1:0] {
		OP_OPEN,
		OP_PIXEL,
		OP_CLOSE,
		OP_CURSOR
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic [NUM_DATA-1:0][15:0] data;
	} entry_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} fifo_stat_t;

endpackage

@@ hdl/lwpcw_front.sv @@
// ----------------------------------------------------------------------------
// lwpcw_front
// Holds the configuration, accepts requests, maps coordinates and builds
// the data words of one queue entry per request of a known kind.
// ----------------------------------------------------------------------------
module lwpcw_front import lwpcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [8:0]  x_first,
	input  logic [8:0]  y_first,
	input  logic [8:0]  x_last,
	input  logic [8:0]  y_last,
	input  logic [23:0] color,
	input  fifo_stat_t  fifo_stat,
	output logic        push,
	output entry_t      push_entry
);

	logic [1:0]  orient_q;
	logic [8:0]  width_q;
	logic [7:0]  height_q;
	logic [15:0] entry_mode_q;

	logic [15:0] w16, h16;
	logic [15:0] col_f, col_l, row_f, row_l;
	logic        accept;
	logic        known_kind;

	assign cfg_ready = 1'b1;
	assign in_ready  = !fifo_stat.full;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q     <= ORIENT_PORTRAIT;
			width_q      <= 9'd320;
			height_q     <= 8'd240;
			entry_mode_q <= 16'd48;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ORIENTATION: orient_q     <= cfg_data[1:0];
				CFG_WIDTH:       width_q      <= cfg_data[8:0];
				CFG_HEIGHT:      height_q     <= cfg_data[7:0];
				CFG_ENTRY_MODE:  entry_mode_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w16 = {7'd0, width_q};
	assign h16 = {8'd0, height_q};

	function automatic logic [15:0] map_col(input logic [1:0] o, input logic [15:0] w,
		input logic [8:0] x, input logic [8:0] y);
		logic [15:0] r;
		unique case (o)
			ORIENT_PORTRAIT:      r = w - {7'd0, y} - 16'd1;
			ORIENT_LANDSCAPE:     r = w - {7'd0, x} - 16'd1;
			ORIENT_PORTRAIT_FLIP: r = {7'd0, y};
			default:              r = {7'd0, x};
		endcase
		return r;
	endfunction

	function automatic logic [15:0] map_row(input logic [1:0] o, input logic [15:0] h,
		input logic [8:0] x, input logic [8:0] y);
		logic [15:0] r;
		unique case (o)
			ORIENT_PORTRAIT:      r = {7'd0, x};
			ORIENT_LANDSCAPE:     r = h - {7'd0, y} - 16'd1;
			ORIENT_PORTRAIT_FLIP: r = h - {7'd0, x} - 16'd1;
			default:              r = {7'd0, y};
		endcase
		return r;
	endfunction

	assign col_f = map_col(orient_q, w16, x_first, y_first);
	assign col_l = map_col(orient_q, w16, x_last, y_last);
	assign row_f = map_row(orient_q, h16, x_first, y_first);
	assign row_l = map_row(orient_q, h16, x_last, y_last);

	always_comb begin
		logic swap_h;
		logic first_low;
		logic [15:0] h_less;
		swap_h     = (orient_q == ORIENT_PORTRAIT) || (orient_q == ORIENT_LANDSCAPE);
		first_low  = (orient_q == ORIENT_PORTRAIT) || (orient_q == ORIENT_LANDSCAPE_FLIP);
		h_less     = h16 - 16'd1;
		known_kind = 1'b1;
		push_entry = '0;
		unique case (kind)
			KIND_OPEN: begin
				push_entry.op      = OP_OPEN;
				push_entry.data[0] = entry_mode_q;
				push_entry.data[1] = swap_h ? col_l : col_f;
				push_entry.data[2] = swap_h ? col_f : col_l;
				push_entry.data[3] = first_low ? ({row_l[7:0], 8'h00} | row_f)
				                               : ({row_f[7:0], 8'h00} | row_l);
				push_entry.data[4] = col_f;
				push_entry.data[5] = row_f;
			end
			KIND_RGB888: begin
				push_entry.op      = OP_PIXEL;
				push_entry.data[0] = {color[23:19], color[15:10], color[7:3]};
			end
			KIND_RGB565: begin
				push_entry.op      = OP_PIXEL;
				push_entry.data[0] = color[15:0];
			end
			KIND_CLOSE: begin
				push_entry.op      = OP_CLOSE;
				push_entry.data[1] = 16'd0;
				push_entry.data[2] = w16 - 16'd1;
				push_entry.data[3] = {h_less[7:0], 8'h00};
			end
			KIND_CURSOR: begin
				push_entry.op      = OP_CURSOR;
				push_entry.data[4] = col_f;
				push_entry.data[5] = row_f;
			end
			default: known_kind = 1'b0;
		endcase
	end

	// unused kinds are taken and dropped
	assign push = accept && known_kind;

endmodule

@@ hdl/lwpcw_fifo.sv @@
// ----------------------------------------------------------------------------
// lwpcw_fifo
// Short request queue that decouples the front from the word sequencer.
// ----------------------------------------------------------------------------
module lwpcw_fifo import lwpcw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  entry_t     push_entry,
	input  logic       pop,
	output entry_t     head,
	output fifo_stat_t stat
);

	entry_t             mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			if (push && !pop)      count_q <= count_q + FIFO_CW'(1);
			else if (pop && !push) count_q <= count_q - FIFO_CW'(1);
		end
	end

	assign head           = mem[rd_ptr_q];
	assign stat.full      = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign stat.not_empty = (count_q != '0);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> stat.not_empty)
		else $error("pop from empty queue");

endmodule

@@ hdl/lwpcw_back.sv @@
// ----------------------------------------------------------------------------
// lwpcw_back
// Word sequencer: walks the command/data steps of the queued request and
// feeds the output register.
// ----------------------------------------------------------------------------
module lwpcw_back import lwpcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head,
	input  fifo_stat_t  fifo_stat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] word,
	output logic        is_command,
	output logic        last_of_run
);

	// steps: even ones are register indexes, odd ones carry data[step/2]
	logic [3:0]  step_q;
	logic        mid_q;
	logic        out_valid_q;
	logic [15:0] word_q;
	logic        is_command_q;
	logic        last_q;

	logic [3:0]  cur_step;
	logic [3:0]  end_step;
	logic [3:0]  first_step;
	logic        load;
	logic        at_end;
	logic [15:0] cur_word;

	always_comb begin
		unique case (head.op)
			OP_OPEN:   begin first_step = 4'd0; end_step = 4'd12; end
			OP_PIXEL:  begin first_step = 4'd1; end_step = 4'd1;  end
			OP_CLOSE:  begin first_step = 4'd2; end_step = 4'd7;  end
			default:   begin first_step = 4'd8; end_step = 4'd12; end
		endcase
	end

	assign cur_step = mid_q ? step_q : first_step;
	assign at_end   = (cur_step == end_step);

	always_comb begin
		unique case (cur_step)
			4'd0:    cur_word = CMD_ENTRY_MODE;
			4'd1:    cur_word = head.data[0];
			4'd2:    cur_word = CMD_H_START;
			4'd3:    cur_word = head.data[1];
			4'd4:    cur_word = CMD_H_END;
			4'd5:    cur_word = head.data[2];
			4'd6:    cur_word = CMD_V_BOUNDS;
			4'd7:    cur_word = head.data[3];
			4'd8:    cur_word = CMD_CURSOR_X;
			4'd9:    cur_word = head.data[4];
			4'd10:   cur_word = CMD_CURSOR_Y;
			4'd11:   cur_word = head.data[5];
			4'd12:   cur_word = CMD_RAM_WRITE;
			default: cur_word = 16'd0;
		endcase
	end

	assign load = fifo_stat.not_empty && (!out_valid_q || out_ready);
	assign pop  = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			mid_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mid_q  <= !at_end;
				step_q <= cur_step + 4'd1;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q       <= cur_word;
			is_command_q <= !cur_step[0];
			last_q       <= at_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign word        = word_q;
	assign is_command  = is_command_q;
	assign last_of_run = last_q;

	a_mid_holds_head: assert property (@(posedge clk) disable iff (!arst_n)
		mid_q |-> fifo_stat.not_empty)
		else $error("request left the queue in mid sequence");

	a_ram_write_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_command_q && word_q == CMD_RAM_WRITE) |-> last_q)
		else $error("ram write command not marked last");

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid_q && last_q))
		else $error("request retired without a last word");

endmodule

@@ hdl/lcd_window_pixel_command_writer.sv @@
// ----------------------------------------------------------------------------
// lcd_window_pixel_command_writer
// Turns window, cursor and pixel requests into panel command/data words.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//  in       in_valid/in_ready     kind, x_first, y_first, x_last, y_last, color
//  out      out_valid/out_ready   word, is_command, last_of_run
//
//  one output word per cycle while out_ready holds and the queue is not empty;
//  a pixel is one word, a cursor request 5, a close 6, an open 13 words, set
//  by the word sequencer. with the queue empty and the output register free,
//  an accepted request goes into the queue, then on into the output register.
//  the 4-entry request queue keeps input accepting while the sequencer or
//  the output stalls; in_ready drops only when the queue is full.
//  reset restores 320x240 portrait, entry mode 48, and empties the queue.
// ----------------------------------------------------------------------------
module lcd_window_pixel_command_writer import lwpcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [8:0]  x_first,
	input  logic [8:0]  y_first,
	input  logic [8:0]  x_last,
	input  logic [8:0]  y_last,
	input  logic [23:0] color,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] word,
	output logic        is_command,
	output logic        last_of_run
);

	fifo_stat_t fifo_stat;
	logic       push;
	logic       pop;
	entry_t     push_entry;
	entry_t     head;

	lwpcw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.x_first    (x_first),
		.y_first    (y_first),
		.x_last     (x_last),
		.y_last     (y_last),
		.color      (color),
		.fifo_stat  (fifo_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	lwpcw_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (fifo_stat)
	);

	lwpcw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.fifo_stat   (fifo_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.word        (word),
		.is_command  (is_command),
		.last_of_run (last_of_run)
	);

endmodule
